### rtl/assert_macros.svh
// Assertion helpers for the odometry integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/podo_pkg.sv
package podo_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_VEL  = 2'd1,
    CMD_POSE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic               is_pose;
    logic signed [23:0] speed;
    logic signed [23:0] turn_rate;
    logic        [15:0] elapsed;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] heading;
  } job_t;

  localparam int ATAN_N = 24;
  localparam logic signed [63:0] CORDIC_X0 = 64'sd652032874;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/podo_front.sv
module podo_front
  import podo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [23:0] in_speed_in,
  input  logic signed [23:0] in_turn_rate_in,
  input  logic [15:0]        in_elapsed_time,
  input  logic signed [31:0] in_new_x,
  input  logic signed [31:0] in_new_y,
  input  logic [15:0]        in_new_heading,
  output logic               q_valid,
  input  logic               q_pop,
  output job_t               q_job,
  output logic signed [23:0] speed,
  output logic signed [23:0] turn_rate
);

  job_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic signed [23:0] speed_r, turn_r;
  logic acc, push;
  cmd_t cmd;
  job_t job;

  assign cmd = cmd_t'(in_command);
  assign in_stall = (cnt_r == 2'd2);
  assign acc = in_valid && !in_stall;
  assign push = acc && (cmd == CMD_TICK || cmd == CMD_POSE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = q_r[rp_r];
  assign speed = speed_r;
  assign turn_rate = turn_r;

  // Each queued job carries the velocity in force when it was accepted.
  always_comb begin
    job.is_pose = (cmd == CMD_POSE);
    job.speed = speed_r;
    job.turn_rate = turn_r;
    job.elapsed = in_elapsed_time;
    job.x = in_new_x;
    job.y = in_new_y;
    job.heading = in_new_heading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      speed_r <= '0;
      turn_r <= '0;
    end else begin
      if (acc && cmd == CMD_VEL) begin
        speed_r <= in_speed_in;
        turn_r <= in_turn_rate_in;
      end
      if (push) begin
        q_r[wp_r] <= job;
        wp_r <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3, "queue count out of range")

endmodule

### rtl/podo_back.sv
module podo_back
  import podo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  job_t               q_job,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_report_kind,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic [15:0]        out_heading_out,
  output logic signed [23:0] out_speed_out,
  output logic signed [23:0] out_turn_rate_out
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(STEPS - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ROT, S_ROUND, S_MOVE, S_ADD} st_t;

  st_t st_r;
  logic [4:0] i_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0] hd_r;
  logic signed [63:0] cx_r, cy_r, cz_r;
  logic signed [24:0] d_r;
  logic signed [16:0] c_r, s_r;
  logic flip_r;
  logic signed [41:0] mx_r, my_r;
  logic signed [23:0] sp_r, tr_r;
  logic [15:0] t_r;

  logic signed [40:0] prod_a, prod_d;
  logic [15:0] hnew;
  logic [31:0] a32, a_adj;
  logic signed [63:0] xs, ys, at;
  logic signed [16:0] cq, sq;
  logic signed [32:0] sumx, sumy;
  logic fire;

  function automatic logic signed [16:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) return 17'sd32767;
      if (r < -64'sd32768) return -17'sd32768;
      return r[16:0];
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [32:0] v);
    begin
      if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -33'sd2147483648) return 32'sh80000000;
      return v[31:0];
    end
  endfunction

  assign prod_a = tr_r * $signed({1'b0, t_r});
  assign prod_d = sp_r * $signed({1'b0, t_r});
  assign hnew = hd_r + prod_a[31:16];
  assign a32 = {hnew, 16'd0};
  assign a_adj = (a32 >= 32'h40000000 && a32 < 32'hC0000000) ? a32 - 32'h80000000 : a32;
  assign xs = cx_r >>> i_r;
  assign ys = cy_r >>> i_r;
  assign at = $signed({32'd0, atan_lookup(i_r)});
  assign cq = flip_r ? -rnd(cx_r) : rnd(cx_r);
  assign sq = flip_r ? -rnd(cy_r) : rnd(cy_r);
  assign sumx = $signed({px_r[31], px_r}) + $signed({{6{mx_r[41]}}, mx_r[41:15]});
  assign sumy = $signed({py_r[31], py_r}) + $signed({{6{my_r[41]}}, my_r[41:15]});
  assign q_pop = (st_r == S_IDLE) && q_valid && !(out_valid && out_stall);
  assign fire = (st_r == S_ADD) || (q_pop && q_job.is_pose);
  assign out_x_out = px_r;
  assign out_y_out = py_r;
  assign out_heading_out = hd_r;
  assign out_speed_out = sp_r;
  assign out_turn_rate_out = tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      out_report_kind <= KIND_TICK;
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
      sp_r <= '0;
      tr_r <= '0;
      i_r <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            sp_r <= q_job.speed;
            tr_r <= q_job.turn_rate;
            t_r <= q_job.elapsed;
            if (q_job.is_pose) begin
              px_r <= q_job.x;
              py_r <= q_job.y;
              hd_r <= q_job.heading;
              out_report_kind <= KIND_ACK;
            end else begin
              st_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          hd_r <= hnew;
          d_r <= prod_d[40:16];
          flip_r <= (a32 >= 32'h40000000 && a32 < 32'hC0000000);
          cx_r <= CORDIC_X0;
          cy_r <= '0;
          cz_r <= $signed({{32{a_adj[31]}}, a_adj});
          i_r <= '0;
          st_r <= S_ROT;
        end
        S_ROT: begin
          if (!cz_r[63]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == LAST) st_r <= S_ROUND;
        end
        S_ROUND: begin
          c_r <= cq;
          s_r <= sq;
          st_r <= S_MOVE;
        end
        S_MOVE: begin
          mx_r <= d_r * c_r;
          my_r <= d_r * s_r;
          st_r <= S_ADD;
        end
        S_ADD: begin
          px_r <= sat(sumx);
          py_r <= sat(sumy);
          out_report_kind <= KIND_TICK;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x_out),
               "result changed while stalled")
  `ASSERT_IMPL(a_pop_idle, q_pop, st_r == S_IDLE, "job taken while busy")
  `ASSERT_NEXT(a_add_emits, st_r == S_ADD, out_valid && out_report_kind == KIND_TICK,
               "tick finished without report")

endmodule

### rtl/planar_odometry_integrator.sv
// Dead-reckoning pose integrator. A set-velocity transaction updates speed and
// turn rate with no result; a set-pose transaction loads the pose and is
// acknowledged; a tick advances heading and position with an iterative CORDIC
// and reports the pose. A set-pose result is registered when the back end takes
// it from the queue; a tick passes through S_MUL, the one-step-per-cycle CORDIC
// rotator in S_ROT, S_ROUND, S_MOVE and S_ADD, which keep the back end busy; a
// two-entry queue lets new transactions arrive meanwhile.
module planar_odometry_integrator
  import podo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [23:0] in_speed_in,
  input  logic signed [23:0] in_turn_rate_in,
  input  logic [15:0]        in_elapsed_time,
  input  logic signed [31:0] in_new_x,
  input  logic signed [31:0] in_new_y,
  input  logic [15:0]        in_new_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_report_kind,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic [15:0]        out_heading_out,
  output logic signed [23:0] out_speed_out,
  output logic signed [23:0] out_turn_rate_out
);

  logic q_valid, q_pop;
  job_t q_job;
  logic signed [23:0] speed, turn_rate;

  podo_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_speed_in,
    .in_turn_rate_in, .in_elapsed_time, .in_new_x, .in_new_y, .in_new_heading,
    .q_valid, .q_pop, .q_job, .speed, .turn_rate
  );

  podo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_job, .out_valid, .out_stall,
    .out_report_kind, .out_x_out, .out_y_out, .out_heading_out,
    .out_speed_out, .out_turn_rate_out
  );

`include "assert_macros.svh"
  `ASSERT_IMPL(a_vel_latched, 1'b1, !(turn_rate != turn_rate) && !(speed != speed),
               "velocity register unknown")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
  import podo_pkg::*;
;

  typedef struct {
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] heading;
    logic signed [23:0] speed;
    logic signed [23:0] turn_rate;
  } pose_report_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic signed [23:0] in_speed_in;
  logic signed [23:0] in_turn_rate_in;
  logic [15:0]        in_elapsed_time;
  logic signed [31:0] in_new_x;
  logic signed [31:0] in_new_y;
  logic [15:0]        in_new_heading;
  logic               out_valid;
  logic               out_stall;
  logic               out_report_kind;
  logic signed [31:0] out_x_out;
  logic signed [31:0] out_y_out;
  logic [15:0]        out_heading_out;
  logic signed [23:0] out_speed_out;
  logic signed [23:0] out_turn_rate_out;

  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [15:0] pose_heading;
  logic signed [23:0] cmd_speed;
  logic signed [23:0] cmd_turn_rate;

  pose_report_t pending_reports[$];
  int error_count;
  bit quiet;
  int out_stall_left;

  planar_odometry_integrator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_speed_in       (in_speed_in),
    .in_turn_rate_in   (in_turn_rate_in),
    .in_elapsed_time   (in_elapsed_time),
    .in_new_x          (in_new_x),
    .in_new_y          (in_new_y),
    .in_new_heading    (in_new_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_report_kind   (out_report_kind),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_heading_out   (out_heading_out),
    .out_speed_out     (out_speed_out),
    .out_turn_rate_out (out_turn_rate_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic rotate_heading(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint px, py, z, xs, ys;
    a = {ang, 16'h0000};
    flip = 0;
    px = 652032874;
    py = 0;
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a = a - 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < 16; i++) begin
      xs = px >>> i;
      ys = py >>> i;
      if (z >= 0) begin
        px = px - ys;
        py = py + xs;
        z = z - longint'(atan_lookup(i[4:0]));
      end else begin
        px = px + ys;
        py = py - xs;
        z = z + longint'(atan_lookup(i[4:0]));
      end
    end
    c = round_q15(px);
    s = round_q15(py);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  task automatic advance_pose(input cmd_t cmd, input logic signed [23:0] spd,
                              input logic signed [23:0] trn, input logic [15:0] et,
                              input logic signed [31:0] nx, input logic signed [31:0] ny,
                              input logic [15:0] nh);
    pose_report_t rep;
    longint t, da, d, c, s;
    case (cmd)
      CMD_VEL: begin
        cmd_speed = spd;
        cmd_turn_rate = trn;
        return;
      end
      CMD_POSE: begin
        pose_x = nx;
        pose_y = ny;
        pose_heading = nh;
        rep.kind = KIND_ACK;
      end
      CMD_TICK: begin
        t = longint'(et);
        da = (longint'(cmd_turn_rate) * t) >>> 16;
        d = (longint'(cmd_speed) * t) >>> 16;
        pose_heading = pose_heading + da[15:0];
        rotate_heading(pose_heading, c, s);
        pose_x = clamp32(longint'(pose_x) + ((d * c) >>> 15));
        pose_y = clamp32(longint'(pose_y) + ((d * s) >>> 15));
        rep.kind = KIND_TICK;
      end
      default: return;
    endcase
    rep.x = pose_x;
    rep.y = pose_y;
    rep.heading = pose_heading;
    rep.speed = cmd_speed;
    rep.turn_rate = cmd_turn_rate;
    pending_reports.push_back(rep);
  endtask

  task automatic send_item(input cmd_t cmd, input logic signed [23:0] spd,
                           input logic signed [23:0] trn, input logic [15:0] et,
                           input logic signed [31:0] nx, input logic signed [31:0] ny,
                           input logic [15:0] nh);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_speed_in <= spd;
    in_turn_rate_in <= trn;
    in_elapsed_time <= et;
    in_new_x <= nx;
    in_new_y <= ny;
    in_new_heading <= nh;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    advance_pose(cmd, spd, trn, et, nx, ny, nh);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else begin
      out_stall <= 1'b0;
      out_stall_left = pick_gap();
    end
  end

  always @(negedge clk) begin
    pose_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected transaction count", 64'sd1, 64'sd0);
      end else begin
        want = pending_reports.pop_front();
        if (out_report_kind !== want.kind)
          report_mismatch("report_kind", longint'(out_report_kind), longint'(want.kind));
        if (out_x_out !== want.x) report_mismatch("x", longint'(out_x_out), longint'(want.x));
        if (out_y_out !== want.y) report_mismatch("y", longint'(out_y_out), longint'(want.y));
        if (out_heading_out !== want.heading)
          report_mismatch("heading", longint'(out_heading_out), longint'(want.heading));
        if (out_speed_out !== want.speed)
          report_mismatch("speed", longint'(out_speed_out), longint'(want.speed));
        if (out_turn_rate_out !== want.turn_rate)
          report_mismatch("turn_rate", longint'(out_turn_rate_out), longint'(want.turn_rate));
      end
    end
  end

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic tick(input logic [15:0] et);
    send_item(CMD_TICK, 24'($urandom), 24'($urandom), et, 32'($urandom), 32'($urandom),
              16'($urandom));
  endtask

  task automatic set_velocity(input logic signed [23:0] spd, input logic signed [23:0] trn);
    send_item(CMD_VEL, spd, trn, 16'($urandom), 32'($urandom), 32'($urandom), 16'($urandom));
  endtask

  task automatic set_pose(input logic signed [31:0] nx, input logic signed [31:0] ny,
                          input logic [15:0] nh);
    send_item(CMD_POSE, 24'($urandom), 24'($urandom), 16'($urandom), nx, ny, nh);
  endtask

  task automatic send_unknown();
    send_item(CMD_NONE, 24'($urandom), 24'($urandom), 16'($urandom), 32'($urandom),
              32'($urandom), 16'($urandom));
  endtask

  task automatic run_directed_cases();
    logic [15:0] quadrant_edges[4];
    quadrant_edges = '{16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000};
    set_pose(32'sd0, 32'sd0, 16'd0);
    set_velocity(24'sh7FFFFF, 24'sh7FFFFF);
    tick(16'd0);
    tick(16'hFFFF);
    send_unknown();
    set_pose(32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF);
    set_velocity(24'sh800000, 24'sh800000);
    tick(16'hFFFF);
    set_pose(32'sh7FFF0000, 32'sh7FFF0000, 16'h2000);
    set_velocity(24'sh7FFFFF, 24'sh0);
    tick(16'hFFFF);
    tick(16'hFFFF);
    set_pose(32'sh80010000, 32'sh80010000, 16'hA000);
    tick(16'hFFFF);
    tick(16'hFFFF);
    foreach (quadrant_edges[i]) begin
      set_pose(32'sd0, 32'sd0, quadrant_edges[i]);
      tick(16'h8000);
    end
  endtask

  task automatic run_random_traffic(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        tick(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)));
      end else if (r < 78) begin
        if ($urandom_range(0, 1))
          set_velocity(24'($urandom), 24'($urandom));
        else
          set_velocity($signed(24'($urandom_range(0, 400000))) - 24'sd200000,
                       $signed(24'($urandom_range(0, 200000))) - 24'sd100000);
      end else if (r < 94) begin
        set_pose(32'($urandom), 32'($urandom), 16'($urandom));
      end else begin
        send_unknown();
      end
    end
  endtask

  task automatic run_flush_pause();
    run_random_traffic(30);
    wait_for_reports();
    run_random_traffic(30);
  endtask

  task automatic run_back_to_back();
    quiet = 1;
    run_random_traffic(80);
    quiet = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_TICK;
    in_speed_in = '0;
    in_turn_rate_in = '0;
    in_elapsed_time = '0;
    in_new_x = '0;
    in_new_y = '0;
    in_new_heading = '0;
    out_stall = 1'b0;
    out_stall_left = 0;
    error_count = 0;
    quiet = 0;
    pose_x = '0;
    pose_y = '0;
    pose_heading = '0;
    cmd_speed = '0;
    cmd_turn_rate = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_cases();
    run_random_traffic(300);
    run_flush_pause();
    run_back_to_back();
    run_random_traffic(340);
    wait_for_reports();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
